@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each use stands on a line of its own and takes no trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define GQV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition must never be seen at a clock edge.
`define GQV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define GQV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define GQV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/gqv_pkg.sv @@
package gqv_pkg;

	localparam int FRAC_BITS = 4;
	localparam int COORD_BITS = 24;
	// Headroom for pen plus offsets and the shear term before saturation.
	localparam int EXT_BITS = ((COORD_BITS > 20) ? COORD_BITS : 20) + 3;
	localparam int SHR_BITS = 22 + FRAC_BITS;
	localparam int SHEAR_SHIFT = 10;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_BITS-1:0] ext_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_BASE_SIZE = 3'd0,
		CFG_BOLD = 3'd1,
		CFG_ITALIC = 3'd2,
		CFG_UNDERLINE = 3'd3,
		CFG_COLOR = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_PRE,
		PH_GLYPH,
		PH_POST
	} phase_t;

	typedef struct packed {
		logic [7:0] base_size;
		logic bold_on;
		logic italic_on;
		logic underline_on;
		logic [31:0] text_color;
	} cfg_t;

	// One classified character, as handed from the front end to the back end.
	typedef struct packed {
		logic ul_pre;
		logic glyph;
		logic ul_post;
		logic bold;
		logic italic;
		coord_t pre_x;
		coord_t pre_y;
		coord_t glyph_x;
		coord_t glyph_y;
		coord_t post_x;
		coord_t post_y;
		logic signed [9:0] left;
		logic signed [9:0] top;
		logic [8:0] width;
		logic [8:0] height;
		logic [15:0] u_min;
		logic [15:0] u_max;
		logic [15:0] v_min;
		logic [15:0] v_max;
	} job_t;

	localparam logic [7:0] BASE_RESET = 8'd32;
	localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

	localparam logic [20:0] CHAR_TAB = 21'd9;
	localparam logic [20:0] CHAR_NL = 21'd10;
	localparam logic [20:0] CHAR_VT = 21'd11;
	localparam logic [20:0] CHAR_SPACE = 21'd32;

	// Corner patterns of the two triangles, bit i for vertex i.
	localparam logic [5:0] CORNER_W = 6'b100011;
	localparam logic [5:0] CORNER_H = 6'b110001;
	localparam logic [5:0] UL_USE_X = 6'b011100;
	localparam logic [5:0] UL_UPPER = 6'b001110;

	localparam logic [2:0] LAST_CORNER = 3'd5;
	localparam logic [2:0] COPY_BASE = 3'd0;
	localparam logic [2:0] COPY_LEFT = 3'd1;
	localparam logic [2:0] COPY_RIGHT = 3'd2;
	localparam logic [2:0] COPY_UP = 3'd3;
	localparam logic [2:0] COPY_DOWN = 3'd4;

	localparam logic [11:0] UL_DROP = 12'd2;
	localparam logic [11:0] UL_THIN = 12'd2;
	localparam logic [11:0] UL_BOLD = 12'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	typedef logic [QUEUE_PTR_BITS-1:0] qptr_t;
	typedef logic [QUEUE_PTR_BITS:0] qcount_t;
	localparam qcount_t QUEUE_FULL = qcount_t'(QUEUE_DEPTH);

	localparam ext_t COORD_HI_E = ext_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam ext_t COORD_LO_E = ext_t'(-(64'sd1 <<< (COORD_BITS - 1)));
	localparam ext_t HALF_PIX = ext_t'(64'sd1 <<< (FRAC_BITS - 1));
	localparam coord_t PEN_Y_RESET = coord_t'(64'sd32 <<< FRAC_BITS);

	localparam logic signed [SHR_BITS-1:0] SHEAR_MUL = SHR_BITS'(213);
	localparam logic signed [SHR_BITS-1:0] SHEAR_RND = SHR_BITS'(512);

	function automatic coord_t sat_coord(input ext_t v);
		coord_t r;
		if (v > COORD_HI_E) r = coord_t'(COORD_HI_E);
		else if (v < COORD_LO_E) r = coord_t'(COORD_LO_E);
		else r = coord_t'(v);
		return r;
	endfunction

	function automatic ext_t fx_u(input logic [11:0] px);
		return ext_t'(px) <<< FRAC_BITS;
	endfunction

	function automatic ext_t fx_s(input logic signed [11:0] px);
		return ext_t'(px) <<< FRAC_BITS;
	endfunction

	// Italic shear of a pixel height, rounded to nearest with ties rounded up.
	function automatic ext_t shear_fx(input logic signed [10:0] p);
		logic signed [SHR_BITS-1:0] n;
		n = (SHR_BITS'(p) * SHEAR_MUL) <<< FRAC_BITS;
		n = n + SHEAR_RND;
		return ext_t'(n >>> SHEAR_SHIFT);
	endfunction

endpackage

@@ rtl/gqv_front.sv @@
module gqv_front (
	input logic clk,
	input logic arst_n,
	input gqv_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic [20:0] char_code,
	input logic glyph_present,
	input logic signed [9:0] glyph_left,
	input logic signed [9:0] glyph_top,
	input logic [8:0] glyph_width,
	input logic [8:0] glyph_height,
	input logic [9:0] glyph_advance,
	input logic [15:0] tex_u_min,
	input logic [15:0] tex_u_max,
	input logic [15:0] tex_v_min,
	input logic [15:0] tex_v_max,
	input logic end_of_string,
	input logic q_full,
	output logic push,
	output gqv_pkg::job_t job
);

	gqv_pkg::coord_t pen_x_q, pen_y_q;
	gqv_pkg::coord_t x1, x2, y1, px_g, py_g, nxt_x, nxt_y;
	gqv_pkg::ext_t base_fx, adv_fx, dx, dy, x_from;
	logic accept, is_nl, is_sp, is_tab, is_vt;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// Pen arithmetic. All moves along x are non-negative, so the space and tab
	// step and the advance can be summed first and saturated once.
	always_comb begin
		is_nl = char_code == gqv_pkg::CHAR_NL;
		is_sp = char_code == gqv_pkg::CHAR_SPACE;
		is_tab = char_code == gqv_pkg::CHAR_TAB;
		is_vt = char_code == gqv_pkg::CHAR_VT;
		base_fx = gqv_pkg::fx_u(12'(cfg.base_size));
		adv_fx = gqv_pkg::fx_u(12'(glyph_advance));
		dx = '0;
		dy = '0;
		if (is_sp) dx = adv_fx;
		else if (is_tab) dx = base_fx <<< 2;
		if (is_nl) dy = base_fx;
		else if (is_vt) dy = base_fx <<< 2;
		x_from = is_nl ? '0 : gqv_pkg::ext_t'(pen_x_q);
		x1 = gqv_pkg::sat_coord(x_from + dx);
		x2 = gqv_pkg::sat_coord(x_from + dx + adv_fx);
		y1 = gqv_pkg::sat_coord(gqv_pkg::ext_t'(pen_y_q) + dy);
		px_g = glyph_present ? x2 : pen_x_q;
		py_g = glyph_present ? y1 : pen_y_q;
		nxt_x = end_of_string ? '0 : px_g;
		nxt_y = end_of_string ? gqv_pkg::sat_coord(base_fx) : py_g;
	end

	always_comb begin
		job.ul_pre = glyph_present && is_nl && cfg.underline_on;
		job.glyph = glyph_present;
		job.ul_post = end_of_string && cfg.underline_on;
		job.bold = cfg.bold_on;
		job.italic = cfg.italic_on;
		job.pre_x = pen_x_q;
		job.pre_y = pen_y_q;
		job.glyph_x = x1;
		job.glyph_y = y1;
		job.post_x = px_g;
		job.post_y = py_g;
		job.left = glyph_left;
		job.top = glyph_top;
		job.width = glyph_width;
		job.height = glyph_height;
		job.u_min = tex_u_min;
		job.u_max = tex_u_max;
		job.v_min = tex_v_min;
		job.v_max = tex_v_max;
	end

	// Items that produce no vertex only move the pen.
	assign push = accept && (glyph_present || (end_of_string && cfg.underline_on));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= gqv_pkg::PEN_Y_RESET;
		end else if (accept) begin
			pen_x_q <= nxt_x;
			pen_y_q <= nxt_y;
		end
	end

endmodule

@@ rtl/gqv_queue.sv @@
module gqv_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input gqv_pkg::job_t push_job,
	input logic pop,
	output logic full,
	output logic head_valid,
	output gqv_pkg::job_t head
);

	gqv_pkg::job_t mem_q [gqv_pkg::QUEUE_DEPTH];
	gqv_pkg::qptr_t wr_ptr_q, rd_ptr_q;
	gqv_pkg::qcount_t count_q;

	assign full = count_q == gqv_pkg::QUEUE_FULL;
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + gqv_pkg::qptr_t'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + gqv_pkg::qptr_t'(1);
			case ({push, pop})
				2'b10: count_q <= count_q + gqv_pkg::qcount_t'(1);
				2'b01: count_q <= count_q - gqv_pkg::qcount_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/gqv_back.sv @@
`include "assert_macros.svh"

module gqv_back (
	input logic clk,
	input logic arst_n,
	input gqv_pkg::cfg_t cfg,
	input logic head_valid,
	input gqv_pkg::job_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic signed [gqv_pkg::COORD_BITS-1:0] vertex_x,
	output logic signed [gqv_pkg::COORD_BITS-1:0] vertex_y,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic [31:0] vertex_color,
	output logic is_underline,
	output logic last_of_run
);

	gqv_pkg::phase_t phase_q, phase_d, cur_ph;
	logic [2:0] corner_q, corner_d, copy_q, copy_d, copy_last;
	logic issue, last_vtx, s1_adv, s2_adv;

	gqv_pkg::coord_t ul_x, ul_py, ul_y0, px_d, py_d;
	gqv_pkg::ext_t ul_t, ox, oy, g_shear, ax_d, ay_d;
	logic signed [11:0] gx_px, gy_px;
	logic signed [10:0] sh_arg;
	logic [8:0] ww, hh;
	logic cw, chh, und_d;
	logic [15:0] u_d, v_d;

	logic valid_s1, und_s1, last_s1;
	gqv_pkg::coord_t px_s1, py_s1;
	gqv_pkg::ext_t ax_s1, ay_s1;
	logic [15:0] u_s1, v_s1;

	logic valid_s2, und_s2, last_s2;
	gqv_pkg::coord_t x_s2, y_s2;
	logic [15:0] u_s2, v_s2;

	assign s2_adv = !valid_s2 || !out_stall;
	assign s1_adv = !valid_s1 || s2_adv;
	assign issue = head_valid && s1_adv;
	assign pop = issue && last_vtx;

	// Sequencer next state: underline before, glyph copies, underline after.
	always_comb begin
		if (phase_q == gqv_pkg::PH_PRE && head.ul_pre) cur_ph = gqv_pkg::PH_PRE;
		else if (phase_q != gqv_pkg::PH_POST && head.glyph) cur_ph = gqv_pkg::PH_GLYPH;
		else cur_ph = gqv_pkg::PH_POST;
		copy_last = head.bold ? gqv_pkg::COPY_DOWN : gqv_pkg::COPY_BASE;
		last_vtx = 1'b0;
		unique case (cur_ph)
			gqv_pkg::PH_PRE: last_vtx = !head.glyph && !head.ul_post;
			gqv_pkg::PH_GLYPH: last_vtx = copy_q == copy_last && !head.ul_post;
			gqv_pkg::PH_POST: last_vtx = 1'b1;
			default: last_vtx = 1'b1;
		endcase
		last_vtx = last_vtx && corner_q == gqv_pkg::LAST_CORNER;

		phase_d = phase_q;
		corner_d = corner_q;
		copy_d = copy_q;
		if (issue) begin
			if (last_vtx) begin
				phase_d = gqv_pkg::PH_PRE;
				corner_d = '0;
				copy_d = gqv_pkg::COPY_BASE;
			end else if (corner_q == gqv_pkg::LAST_CORNER) begin
				corner_d = '0;
				unique case (cur_ph)
					gqv_pkg::PH_PRE: begin
						phase_d = gqv_pkg::PH_GLYPH;
					end
					gqv_pkg::PH_GLYPH: begin
						if (copy_q != copy_last) begin
							phase_d = gqv_pkg::PH_GLYPH;
							copy_d = copy_q + 3'd1;
						end else begin
							phase_d = gqv_pkg::PH_POST;
							copy_d = gqv_pkg::COPY_BASE;
						end
					end
					default: phase_d = gqv_pkg::PH_POST;
				endcase
			end else begin
				phase_d = cur_ph;
				corner_d = corner_q + 3'd1;
			end
		end
	end

	// Operands of the current vertex; the final add and clamp come one stage later.
	always_comb begin
		ul_x = (cur_ph == gqv_pkg::PH_PRE) ? head.pre_x : head.post_x;
		ul_py = (cur_ph == gqv_pkg::PH_PRE) ? head.pre_y : head.post_y;
		ul_y0 = gqv_pkg::sat_coord(gqv_pkg::ext_t'(ul_py) - gqv_pkg::fx_u(gqv_pkg::UL_DROP));
		ul_t = gqv_pkg::fx_u(head.bold ? gqv_pkg::UL_BOLD : gqv_pkg::UL_THIN);

		cw = gqv_pkg::CORNER_W[corner_q];
		chh = gqv_pkg::CORNER_H[corner_q];
		ww = cw ? head.width : '0;
		hh = chh ? head.height : '0;
		ox = '0;
		oy = '0;
		case (copy_q)
			gqv_pkg::COPY_LEFT: ox = -gqv_pkg::HALF_PIX;
			gqv_pkg::COPY_RIGHT: ox = gqv_pkg::HALF_PIX;
			gqv_pkg::COPY_UP: oy = -gqv_pkg::HALF_PIX;
			gqv_pkg::COPY_DOWN: oy = gqv_pkg::HALF_PIX;
			default: ox = '0;
		endcase
		gx_px = 12'(head.left) + $signed({3'b000, ww});
		gy_px = 12'(head.top) + $signed({3'b000, hh});
		sh_arg = -11'(head.top) - $signed({2'b00, hh});
		g_shear = head.italic ? gqv_pkg::shear_fx(sh_arg) : '0;

		px_d = gqv_pkg::UL_USE_X[corner_q] ? ul_x : '0;
		ax_d = '0;
		py_d = ul_y0;
		ay_d = gqv_pkg::UL_UPPER[corner_q] ? ul_t : '0;
		u_d = '0;
		v_d = '0;
		und_d = 1'b1;
		if (cur_ph == gqv_pkg::PH_GLYPH) begin
			px_d = head.glyph_x;
			ax_d = ox + gqv_pkg::fx_s(gx_px) + g_shear;
			py_d = head.glyph_y;
			ay_d = oy - gqv_pkg::fx_s(gy_px);
			u_d = cw ? head.u_max : head.u_min;
			v_d = chh ? head.v_min : head.v_max;
			und_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gqv_pkg::PH_PRE;
			corner_q <= '0;
			copy_q <= gqv_pkg::COPY_BASE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			phase_q <= phase_d;
			corner_q <= corner_d;
			copy_q <= copy_d;
			if (s1_adv) valid_s1 <= issue;
			if (s2_adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			px_s1 <= px_d;
			ax_s1 <= ax_d;
			py_s1 <= py_d;
			ay_s1 <= ay_d;
			u_s1 <= u_d;
			v_s1 <= v_d;
			und_s1 <= und_d;
			last_s1 <= last_vtx;
		end
		if (s2_adv && valid_s1) begin
			x_s2 <= gqv_pkg::sat_coord(gqv_pkg::ext_t'(px_s1) + ax_s1);
			y_s2 <= gqv_pkg::sat_coord(gqv_pkg::ext_t'(py_s1) + ay_s1);
			u_s2 <= u_s1;
			v_s2 <= v_s1;
			und_s2 <= und_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign vertex_x = x_s2;
	assign vertex_y = y_s2;
	assign tex_u = u_s2;
	assign tex_v = v_s2;
	assign vertex_color = cfg.text_color;
	assign is_underline = und_s2;
	assign last_of_run = last_s2;

	`GQV_ASSERT_IMPLY(a_post_needs_ul, clk, arst_n, head_valid && phase_q == gqv_pkg::PH_POST, head.ul_post, "closing underline phase entered without an underline")
	`GQV_ASSERT_IMPLY(a_copy_only_bold, clk, arst_n, head_valid && !head.bold, copy_q == gqv_pkg::COPY_BASE, "offset copy stepped for a regular glyph")
	`GQV_ASSERT_NEVER(a_corner_range, clk, arst_n, corner_q > gqv_pkg::LAST_CORNER, "corner counter out of range")
	`GQV_ASSERT_IMPLY(a_ul_no_tex, clk, arst_n, valid_s2 && und_s2, tex_u == '0 && tex_v == '0, "underline vertex carries texture coordinates")

endmodule

@@ rtl/glyph_quad_vertex_generator.sv @@
// Glyph quad vertex generator.
// Input channel (in_valid / in_stall): one character per item with its glyph
// metrics and atlas corners. Output channel (out_valid / out_stall): one vertex
// per item, two triangles per quad; last_of_run marks the final vertex that a
// character causes. Configuration is written through cfg_we / cfg_index /
// cfg_data while the block is idle; unknown indices are ignored.
// Throughput: one vertex per cycle while the output is not stalled; a plain
// glyph gives 6 vertices, a bold glyph 30, and each underline quad adds 6
// (at most 42 for one character), as the back-end sequencer walks them.
// An item's first vertex passes the queue, operand and output registers.
// A two-entry queue sits between the classifying front end and the vertex
// sequencer, so characters are taken while earlier quads are still drawn;
// in_stall rises only when that queue is full. Characters with no glyph and
// no closing underline are absorbed at once and emit nothing.
// Reset clears the pen to x = 0, y = 32 pixels, restores the register
// defaults and empties the queue and pipeline. When the receiver stalls, the
// output register holds its vertex, the sequencer freezes, and the queue
// fills before the input side is stalled.
module glyph_quad_vertex_generator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [gqv_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [gqv_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [20:0] char_code,
	input logic glyph_present,
	input logic signed [9:0] glyph_left,
	input logic signed [9:0] glyph_top,
	input logic [8:0] glyph_width,
	input logic [8:0] glyph_height,
	input logic [9:0] glyph_advance,
	input logic [15:0] tex_u_min,
	input logic [15:0] tex_u_max,
	input logic [15:0] tex_v_min,
	input logic [15:0] tex_v_max,
	input logic end_of_string,
	output logic out_valid,
	input logic out_stall,
	output logic signed [gqv_pkg::COORD_BITS-1:0] vertex_x,
	output logic signed [gqv_pkg::COORD_BITS-1:0] vertex_y,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic [31:0] vertex_color,
	output logic is_underline,
	output logic last_of_run
);

	gqv_pkg::cfg_t cfg_q;
	gqv_pkg::job_t push_job, head;
	logic push, pop, q_full, head_valid;

	// Style and color registers. The user must change them only while no character
	// is in flight (the block does not enforce this); both halves read them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_size <= gqv_pkg::BASE_RESET;
			cfg_q.bold_on <= 1'b0;
			cfg_q.italic_on <= 1'b0;
			cfg_q.underline_on <= 1'b0;
			cfg_q.text_color <= gqv_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gqv_pkg::CFG_BASE_SIZE: cfg_q.base_size <= cfg_data[7:0];
				gqv_pkg::CFG_BOLD: cfg_q.bold_on <= cfg_data[0];
				gqv_pkg::CFG_ITALIC: cfg_q.italic_on <= cfg_data[0];
				gqv_pkg::CFG_UNDERLINE: cfg_q.underline_on <= cfg_data[0];
				gqv_pkg::CFG_COLOR: cfg_q.text_color <= cfg_data[31:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front end: owns the pen, classifies each character and decides which
	// quads it needs (leading underline, glyph copies, closing underline).
	gqv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.glyph_present(glyph_present),
		.glyph_left(glyph_left),
		.glyph_top(glyph_top),
		.glyph_width(glyph_width),
		.glyph_height(glyph_height),
		.glyph_advance(glyph_advance),
		.tex_u_min(tex_u_min),
		.tex_u_max(tex_u_max),
		.tex_v_min(tex_v_min),
		.tex_v_max(tex_v_max),
		.end_of_string(end_of_string),
		.q_full(q_full),
		.push(push),
		.job(push_job)
	);

	gqv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head(head)
	);

	// Back end: steps through the vertices of the head entry, one per cycle unless
	// the output stalls, through an operand stage and a saturating output register.
	gqv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.tex_u(tex_u),
		.tex_v(tex_v),
		.vertex_color(vertex_color),
		.is_underline(is_underline),
		.last_of_run(last_of_run)
	);

endmodule

@@ tb/sv/glyph_quad_checker.sv @@
module glyph_quad_checker
	import gqv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic [20:0] char_code,
	input logic glyph_present,
	input logic signed [9:0] glyph_left,
	input logic signed [9:0] glyph_top,
	input logic [8:0] glyph_width,
	input logic [8:0] glyph_height,
	input logic [9:0] glyph_advance,
	input logic [15:0] tex_u_min,
	input logic [15:0] tex_u_max,
	input logic [15:0] tex_v_min,
	input logic [15:0] tex_v_max,
	input logic end_of_string,
	input logic out_valid,
	input logic out_stall,
	input logic signed [COORD_BITS-1:0] vertex_x,
	input logic signed [COORD_BITS-1:0] vertex_y,
	input logic [15:0] tex_u,
	input logic [15:0] tex_v,
	input logic [31:0] vertex_color,
	input logic is_underline,
	input logic last_of_run,
	output int fail_count,
	output int due_count,
	output int vertex_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
	localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
	localparam longint SLANT_NUM = 213;
	localparam longint SLANT_ROUND = 512;
	localparam int SLANT_SHIFT = 10;
	localparam longint UL_OFFSET_PX = 2;
	localparam longint UL_THIN_PX = 2;
	localparam longint UL_THICK_PX = 3;
	localparam longint TAB_UNITS = 4;
	localparam int MAX_PRINT = 20;
	// Bit i selects the far corner for vertex i of the two triangles.
	localparam logic [5:0] FAR_X = 6'b100011;
	localparam logic [5:0] FAR_Y = 6'b110001;

	typedef struct {
		coord_t x;
		coord_t y;
		logic [15:0] u;
		logic [15:0] v;
		logic [31:0] color;
		logic ul;
		logic last;
	} vertex_t;

	vertex_t due_vertices[$];

	logic [7:0] line_px;
	logic bold;
	logic italic;
	logic uline;
	logic [31:0] color;
	longint pen_x;
	longint pen_y;

	function automatic longint clamp(input longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	function automatic longint to_fx(input longint px);
		return px * (64'sd1 <<< FRAC_BITS);
	endfunction

	// Italic offset of a height in pixels; the arithmetic shift floors.
	function automatic longint slant(input longint px);
		if (!italic) return 0;
		return (px * SLANT_NUM * (64'sd1 <<< FRAC_BITS) + SLANT_ROUND) >>> SLANT_SHIFT;
	endfunction

	function automatic void emit(input longint x, input longint y, input logic [15:0] u,
		input logic [15:0] v, input logic ul);
		vertex_t t;
		t.x = coord_t'(clamp(x));
		t.y = coord_t'(clamp(y));
		t.u = u;
		t.v = v;
		t.color = color;
		t.ul = ul;
		t.last = 1'b0;
		due_vertices.push_back(t);
	endfunction

	function automatic void underline_quad();
		longint y0;
		longint y1;
		y0 = clamp(pen_y - to_fx(UL_OFFSET_PX));
		y1 = clamp(y0 + to_fx(bold ? UL_THICK_PX : UL_THIN_PX));
		emit(0, y0, 16'd0, 16'd0, 1'b1);
		emit(0, y1, 16'd0, 16'd0, 1'b1);
		emit(pen_x, y1, 16'd0, 16'd0, 1'b1);
		emit(pen_x, y1, 16'd0, 16'd0, 1'b1);
		emit(pen_x, y0, 16'd0, 16'd0, 1'b1);
		emit(0, y0, 16'd0, 16'd0, 1'b1);
	endfunction

	task automatic lay_out_char(input logic [20:0] code, input logic present,
		input logic signed [9:0] left, input logic signed [9:0] top,
		input logic [8:0] w, input logic [8:0] h, input logic [9:0] adv,
		input logic [15:0] umin, input logic [15:0] umax,
		input logic [15:0] vmin, input logic [15:0] vmax, input logic eos);
		int start;
		int copies;
		longint base;
		longint lp;
		longint tp;
		longint ww;
		longint hh;
		longint ox;
		longint oy;
		longint half;
		vertex_t tail;
		start = due_vertices.size();
		base = line_px;
		lp = left;
		tp = top;
		half = 64'sd1 <<< (FRAC_BITS - 1);
		if (present) begin
			if (code == CHAR_NL && uline)
				underline_quad();
			case (code)
				CHAR_SPACE: pen_x = clamp(pen_x + to_fx(adv));
				CHAR_NL: begin
					pen_y = clamp(pen_y + to_fx(base));
					pen_x = 0;
				end
				CHAR_TAB: pen_x = clamp(pen_x + to_fx(base * TAB_UNITS));
				CHAR_VT: pen_y = clamp(pen_y + to_fx(base * TAB_UNITS));
				default: ;
			endcase
			copies = bold ? 5 : 1;
			for (int c = 0; c < copies; c++) begin
				ox = 0;
				oy = 0;
				case (c)
					1: ox = -half;
					2: ox = half;
					3: oy = -half;
					4: oy = half;
					default: ;
				endcase
				for (int i = 0; i < 6; i++) begin
					ww = FAR_X[i] ? longint'(w) : 0;
					hh = FAR_Y[i] ? longint'(h) : 0;
					emit(pen_x + ox + to_fx(lp + ww) + slant(-tp - hh),
						pen_y + oy - to_fx(tp + hh),
						FAR_X[i] ? umax : umin, FAR_Y[i] ? vmin : vmax, 1'b0);
				end
			end
			pen_x = clamp(pen_x + to_fx(adv));
		end
		if (eos) begin
			if (uline)
				underline_quad();
			pen_x = 0;
			pen_y = clamp(to_fx(base));
		end
		if (due_vertices.size() > start) begin
			tail = due_vertices.pop_back();
			tail.last = 1'b1;
			due_vertices.push_back(tail);
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		if (fail_count < MAX_PRINT)
			$display("%0t: vertex %0d, %s: got %0d, expected %0d",
				$time, vertex_count, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			line_px = BASE_RESET;
			bold = 1'b0;
			italic = 1'b0;
			uline = 1'b0;
			color = COLOR_RESET;
			pen_x = 0;
			pen_y = clamp(to_fx(BASE_RESET));
			due_vertices.delete();
			fail_count = 0;
			vertex_count = 0;
			due_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BASE_SIZE: line_px = cfg_data[7:0];
					CFG_BOLD: bold = cfg_data[0];
					CFG_ITALIC: italic = cfg_data[0];
					CFG_UNDERLINE: uline = cfg_data[0];
					CFG_COLOR: color = cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				lay_out_char(char_code, glyph_present, glyph_left, glyph_top,
					glyph_width, glyph_height, glyph_advance, tex_u_min, tex_u_max,
					tex_v_min, tex_v_max, end_of_string);
			if (out_valid && !out_stall) begin
				if (due_vertices.size() == 0) begin
					report("vertex with nothing due", 0, 0);
				end else begin
					want = due_vertices.pop_front();
					if (vertex_x !== want.x) report("vertex_x", vertex_x, want.x);
					if (vertex_y !== want.y) report("vertex_y", vertex_y, want.y);
					if (tex_u !== want.u) report("tex_u", tex_u, want.u);
					if (tex_v !== want.v) report("tex_v", tex_v, want.v);
					if (vertex_color !== want.color)
						report("vertex_color", vertex_color, want.color);
					if (is_underline !== want.ul)
						report("is_underline", is_underline, want.ul);
					if (last_of_run !== want.last)
						report("last_of_run", last_of_run, want.last);
				end
				vertex_count++;
			end
			due_count <= due_vertices.size();
		end
	end

endmodule

@@ tb/sv/glyph_quad_vertex_generator_tb.sv @@
module glyph_quad_vertex_generator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gqv_pkg::*;

	// Indices 5 to 7 decode to no register; writes there must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd5;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT = 5000;
	localparam int RANDOM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 14;
	localparam int CLIMB_ITEMS = 260;
	localparam longint RUN_LIMIT_NS = 20_000_000;
	localparam logic [20:0] CODE_MAX = 21'd1114111;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [20:0] char_code = '0;
	logic glyph_present = 1'b0;
	logic signed [9:0] glyph_left = '0;
	logic signed [9:0] glyph_top = '0;
	logic [8:0] glyph_width = '0;
	logic [8:0] glyph_height = '0;
	logic [9:0] glyph_advance = '0;
	logic [15:0] tex_u_min = '0;
	logic [15:0] tex_u_max = '0;
	logic [15:0] tex_v_min = '0;
	logic [15:0] tex_v_max = '0;
	logic end_of_string = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic [15:0] tex_u;
	logic [15:0] tex_v;
	logic [31:0] vertex_color;
	logic is_underline;
	logic last_of_run;

	int fail_count;
	int due_count;
	int vertex_count;

	// When set, neither side inserts idle cycles, so the block runs flat out.
	bit steady = 1'b0;
	int chars_sent = 0;
	int styles_used = 0;

	typedef struct {
		logic [20:0] code;
		logic present;
		logic signed [9:0] left;
		logic signed [9:0] top;
		logic [8:0] w;
		logic [8:0] h;
		logic [9:0] adv;
		logic [15:0] umin;
		logic [15:0] umax;
		logic [15:0] vmin;
		logic [15:0] vmax;
		logic eos;
	} char_item_t;

	glyph_quad_vertex_generator DUT (.*);

	// The checker watches the same nets as the block and keeps its own pen.
	glyph_quad_checker vertex_check (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// The receiver may stall at random before taking each vertex. The
	// stall is only raised at the start of a wait, so a single nonblocking
	// update lands on out_stall in any one time step.
	initial begin
		int hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Hard stop in case the block hangs or loses vertices.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Run did not finish within %0d ns.", RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one character and holds it until the block takes it. Valid is
	// lowered only at the start of a gap, never in the step where it rises.
	task automatic send_char(input char_item_t c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c.code;
		glyph_present <= c.present;
		glyph_left <= c.left;
		glyph_top <= c.top;
		glyph_width <= c.w;
		glyph_height <= c.h;
		glyph_advance <= c.adv;
		tex_u_min <= c.umin;
		tex_u_max <= c.umax;
		tex_v_min <= c.vmin;
		tex_v_max <= c.vmax;
		end_of_string <= c.eos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		chars_sent++;
	endtask

	// Drops valid, waits for every predicted vertex to come out or for the drain
	// limit, then lets a few more cycles pass for characters that emit nothing but
	// still update the pen inside the block.
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Writes every register. The unused upper data bits carry noise, which the
	// block has to mask away, and a stray write to an undecoded index follows.
	task automatic set_style(input logic [7:0] base, input logic b, input logic i,
		input logic u, input logic [31:0] rgba);
		write_reg(CFG_COLOR, rgba);
		write_reg(CFG_BASE_SIZE, {24'($urandom), base});
		write_reg(CFG_BOLD, {31'($urandom), b});
		write_reg(CFG_ITALIC, {31'($urandom), i});
		write_reg(CFG_UNDERLINE, {31'($urandom), u});
		write_reg(CFG_IDX_UNUSED + 3'($urandom_range(0, 2)), $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
		styles_used++;
	endtask

	function automatic char_item_t make_char(input logic [20:0] code, input logic present,
		input int left, input int top, input int w, input int h, input int adv,
		input logic eos);
		char_item_t c;
		c.code = code;
		c.present = present;
		c.left = 10'(left);
		c.top = 10'(top);
		c.w = 9'(w);
		c.h = 9'(h);
		c.adv = 10'(adv);
		c.umin = 16'($urandom);
		c.umax = 16'($urandom);
		c.vmin = 16'($urandom);
		c.vmax = 16'($urandom);
		c.eos = eos;
		return c;
	endfunction

	// Mostly printable text with the pen-moving controls mixed in. A few
	// characters take metrics from the full field ranges, and some have no
	// glyph at all.
	function automatic char_item_t random_char(input logic eos);
		char_item_t c;
		int pick;
		logic [20:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 10) code = CHAR_NL;
		else if (pick < 15) code = CHAR_TAB;
		else if (pick < 20) code = CHAR_VT;
		else if (pick < 32) code = CHAR_SPACE;
		else if (pick < 80) code = 21'($urandom_range(33, 126));
		else code = 21'($urandom_range(0, 1114111));
		if ($urandom_range(0, 7) == 0)
			c = make_char(code, 1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1023), eos);
		else
			c = make_char(code, 1'b1, $urandom_range(0, 8) - 2, $urandom_range(0, 40) - 8,
				$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 48), eos);
		c.present = ($urandom_range(0, 9) != 0);
		return c;
	endfunction

	// Whole strings ending in an end-of-string mark, with an occasional string
	// cut off without one so the pen carries over into the next.
	task automatic run_strings(input int count);
		int sent;
		int len;
		bit cut;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 12);
			cut = ($urandom_range(0, 6) == 0);
			for (int k = 0; k < len; k++) begin
				send_char(random_char(k == len - 1 && !cut));
				sent++;
			end
		end
	endtask

	// The short directed list: field extremes, each pen-moving control, a
	// missing glyph with and without a string end, and the code point limits.
	task automatic run_directed();
		send_char(make_char(21'd65, 1'b1, 1, 20, 10, 14, 12, 1'b0));
		send_char(make_char(21'd66, 1'b1, -512, -512, 511, 511, 1023, 1'b0));
		send_char(make_char(21'd67, 1'b1, 511, 511, 0, 0, 0, 1'b0));
		send_char(make_char(CHAR_SPACE, 1'b1, 0, 0, 0, 0, 9, 1'b0));
		send_char(make_char(CHAR_TAB, 1'b1, 0, 3, 2, 3, 5, 1'b0));
		send_char(make_char(CHAR_NL, 1'b1, 0, 7, 4, 4, 0, 1'b0));
		send_char(make_char(CHAR_VT, 1'b1, 2, -3, 5, 6, 7, 1'b0));
		send_char(make_char(21'd68, 1'b0, 3, 10, 8, 9, 11, 1'b0));
		send_char(make_char(CODE_MAX, 1'b1, -1, 1, 1, 1, 1, 1'b0));
		send_char(make_char(21'd0, 1'b1, 0, -1, 3, 5, 4, 1'b0));
		send_char(make_char(21'd69, 1'b1, 4, 12, 6, 12, 8, 1'b1));
		send_char(make_char(21'd70, 1'b0, 0, 0, 0, 0, 0, 1'b1));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed characters under the reset defaults, then again with every
		// style on and a zero line height, where lines stop moving the pen.
		run_directed();
		settle();
		set_style(8'd0, 1'b1, 1'b1, 1'b1, $urandom);
		run_directed();
		settle();

		// Random text under a run of settings: the largest and smallest line
		// heights first, then random ones. Odd phases run with no idle cycles.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_style(8'd255, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
				1: set_style(8'd1, 1'b0, 1'b1, 1'b1, 32'h0000_0000);
				2: set_style(8'd0, 1'b1, 1'b0, 1'b1, $urandom);
				default: set_style(8'($urandom_range(0, 255)), 1'($urandom),
					1'($urandom), 1'($urandom), $urandom);
			endcase
			steady = ph[0];
			run_strings(ITEMS_PER_PHASE);
			settle();
		end
		steady = 1'b0;

		// One long line of tabs with the widest advance drives the pen's x
		// coordinate into saturation; the newline that follows draws its
		// underline at the clamped pen.
		set_style(8'd255, 1'b0, 1'b1, 1'b1, $urandom);
		for (int k = 0; k < CLIMB_ITEMS; k++)
			send_char(make_char(CHAR_TAB, 1'b1, $urandom_range(0, 4), $urandom_range(0, 30),
				$urandom_range(0, 20), $urandom_range(0, 20), 1023, 1'b0));
		send_char(make_char(21'd71, 1'b1, 511, -512, 511, 511, 1023, 1'b0));
		send_char(make_char(CHAR_NL, 1'b1, 0, 5, 3, 3, 1023, 1'b0));
		send_char(make_char(21'd72, 1'b1, 2, 9, 7, 9, 1023, 1'b1));
		settle();

		$display("Sent %0d characters under %0d register settings, including a pen run",
			chars_sent, styles_used + 1);
		$display("into saturation; %0d vertices checked, %0d mismatches, %0d still due.",
			vertex_count, fail_count, due_count);
		if (fail_count == 0 && due_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gqv_pkg.sv
rtl/gqv_front.sv
rtl/gqv_queue.sv
rtl/gqv_back.sv
rtl/glyph_quad_vertex_generator.sv
tb/sv/glyph_quad_checker.sv
tb/sv/glyph_quad_vertex_generator_tb.sv
